### rtl/core/ucd_pkg.sv
// Shared types and constants for the USB-CAN message deframer.
// Holds the input mode codes, the result kind codes and the per-item result record.
// No dependencies.
package ucd_pkg;

  // Item mode codes on the input channel.
  typedef enum logic [1:0] {
    MODE_RX_BYTE   = 2'd0,
    MODE_TX_SUBMIT = 2'd1,
    MODE_TX_FAILED = 2'd2,
    MODE_IGNORED   = 2'd3
  } ucd_mode_t;

  // Result kind codes on the output channel.
  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_FRAME      = 3'd1,
    KIND_WRITE_ACK  = 3'd2,
    KIND_BAD_LENGTH = 3'd3,
    KIND_OTHER      = 3'd4,
    KIND_TX_COUNTED = 3'd5
  } ucd_kind_t;

  // Adapter command bytes.
  localparam logic [7:0] CMD_TS_RECEIVE = 8'h60;
  localparam logic [7:0] CMD_WRITE_ACK  = 8'h5E;
  localparam logic [7:0] MIN_MSG_LEN    = 8'd5;

  // Message byte positions of the captured body fields.
  localparam logic [7:0] POS_STAMP_LO = 8'd6;
  localparam logic [7:0] POS_STAMP_HI = 8'd9;
  localparam logic [7:0] POS_IDENT_LO = 8'd10;
  localparam logic [7:0] POS_IDENT_HI = 8'd13;
  localparam logic [7:0] POS_CODE     = 8'd14;
  localparam logic [7:0] POS_DATA_LO  = 8'd15;
  localparam logic [7:0] POS_DATA_HI  = 8'd22;

  localparam logic [7:0] MAX_OUTSTANDING_RESET = 8'd10;
  localparam logic [3:0] MAX_FRAME_LEN         = 4'd8;

  // Weights of the stamp bytes modulo 1000: 2^16 mod 1000 and 2^24 mod 1000.
  localparam int unsigned STAMP_SUM_W = 18;
  localparam logic [9:0] STAMP_WEIGHT_2 = 10'd536;
  localparam logic [9:0] STAMP_WEIGHT_3 = 10'd216;

  // Reciprocal of 1000 scaled by 2^28, exact for sums below about 493000.
  localparam logic [18:0] RECIP_1000    = 19'd268436;
  localparam int unsigned RECIP_SHIFT   = 28;
  // Inverse of 125 modulo 2^29, used for exact division of multiples of 1000.
  localparam logic [28:0] INV_125       = 29'd115964117;
  localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;

  // One result as it leaves the message parser.
  typedef struct packed {
    ucd_kind_t                kind;
    logic [31:0]              frame_id;
    logic [3:0]               frame_len;
    logic [63:0]              frame_data;
    logic [31:0]              stamp;
    logic [STAMP_SUM_W-1:0]   stamp_sum;
    logic [15:0]              tx_sequence;
    logic [7:0]               outstanding;
    logic                     queue_stopped;
  } ucd_result_t;

endpackage

### rtl/core/usb_can_message_deframer.sv
// Top level of the USB-CAN message deframer: input register, parser, stamp split and
// output register with a common stall. Depends on ucd_pkg, ucd_deframe, ucd_stamp_split.
//
// Takes one item per clock while in_stall is low and gives exactly one result per item,
// in order. The item is loaded into the input register at the accepting edge, then
// passes the parser result register, the stamp division stage and the output register.
// The stamp division by 1000 is what sets the depth. When the output is stalled the
// whole pipe holds, and the input register still takes one more item before in_stall
// rises. Configuration writes are taken every cycle (cfg_ready is always high) and must
// only happen while the block is idle.
module usb_can_message_deframer
  import ucd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic        transfer_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] frame_id,
  output logic [3:0]  frame_len,
  output logic [63:0] frame_data,
  output logic [22:0] stamp_sec,
  output logic [19:0] stamp_usec,
  output logic [15:0] tx_sequence,
  output logic [7:0]  outstanding,
  output logic        queue_stopped
);

  logic        adv;
  logic        fire;
  logic        in_reg_valid;
  logic [1:0]  mode_q;
  logic [7:0]  rx_byte_q;
  logic        transfer_end_q;
  ucd_result_t result;
  logic        s1_valid;
  ucd_result_t s1;
  logic        s2_valid;
  ucd_result_t s2;
  logic [22:0] sec_calc;
  logic [19:0] usec_calc;

  // The pipe moves unless a finished result is held at the output.
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = in_reg_valid && !adv;
  assign fire      = in_reg_valid && adv;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      mode_q         <= mode;
      rx_byte_q      <= rx_byte;
      transfer_end_q <= transfer_end;
    end
  end

  ucd_deframe u_deframe (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .mode         (mode_q),
    .rx_byte      (rx_byte_q),
    .transfer_end (transfer_end_q),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .result       (result)
  );

  // Result register and the stage that runs beside the stamp division.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= fire;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= result;
      s2 <= s1;
    end
  end

  ucd_stamp_split u_stamp_split (
    .clk        (clk),
    .en         (adv),
    .stamp      (s1.stamp),
    .stamp_sum  (s1.stamp_sum),
    .stamp_sec  (sec_calc),
    .stamp_usec (usec_calc)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      kind          <= s2.kind;
      frame_id      <= s2.frame_id;
      frame_len     <= s2.frame_len;
      frame_data    <= s2.frame_data;
      stamp_sec     <= sec_calc;
      stamp_usec    <= usec_calc;
      tx_sequence   <= s2.tx_sequence;
      outstanding   <= s2.outstanding;
      queue_stopped <= s2.queue_stopped;
    end
  end

`ifndef SYNTH
  // Stamp inputs are zero for anything but a frame, so those results carry no time.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1.kind != KIND_FRAME) |-> (s1.stamp == '0) && (s1.stamp_sum == '0))
    else $error("stamp data on a result that is not a frame");

  // The remainder path must land below one second.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stamp_usec < USEC_PER_SEC))
    else $error("microseconds out of range");

  // A frame length is always clamped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FRAME) |-> (frame_len <= MAX_FRAME_LEN))
    else $error("frame length above eight");

  // A result in the middle stage is not lost while the output is held.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !adv |=> s2_valid)
    else $error("pipeline dropped a result under stall");
`endif

endmodule

### rtl/core/ucd_deframe.sv
// Message parser of the USB-CAN deframer: reassembly state, transmit counting and limit.
// Produces one result record per item combinationally; state moves on fire.
// Depends on ucd_pkg.
module ucd_deframe
  import ucd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic        transfer_end,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  output ucd_result_t result
);

  logic [7:0]             max_outstanding;
  logic [7:0]             byte_position;
  logic [7:0]             message_command;
  logic [7:0]             message_length;
  logic [31:0]            stamp_capture;
  logic [STAMP_SUM_W-1:0] stamp_sum;
  logic [31:0]            ident_capture;
  logic [7:0]             code_capture;
  logic [63:0]            payload_capture;
  logic                   skipping;
  logic [7:0]             pending_count;
  logic                   held;
  logic [15:0]            next_sequence;

  logic [7:0]             byte_position_next;
  logic [7:0]             message_command_next;
  logic [7:0]             message_length_next;
  logic [31:0]            stamp_capture_next;
  logic [STAMP_SUM_W-1:0] stamp_sum_next;
  logic [31:0]            ident_capture_next;
  logic [7:0]             code_capture_next;
  logic [63:0]            payload_capture_next;
  logic                   skipping_next;
  logic [7:0]             pending_count_next;
  logic                   held_next;
  logic [15:0]            next_sequence_next;

  // Next state and the result for the item at the input register.
  always_comb begin
    logic [1:0]             stamp_idx;
    logic [1:0]             ident_idx;
    logic [2:0]             data_idx;
    logic [STAMP_SUM_W-1:0] weighted;
    logic [3:0]             len_clamp;
    logic [7:0]             pending_dec;

    byte_position_next   = byte_position;
    message_command_next = message_command;
    message_length_next  = message_length;
    stamp_capture_next   = stamp_capture;
    stamp_sum_next       = stamp_sum;
    ident_capture_next   = ident_capture;
    code_capture_next    = code_capture;
    payload_capture_next = payload_capture;
    skipping_next        = skipping;
    pending_count_next   = pending_count;
    held_next            = held;
    next_sequence_next   = next_sequence;
    result               = '0;
    result.kind          = KIND_NONE;

    stamp_idx   = byte_position[1:0] - 2'd2;
    ident_idx   = byte_position[1:0] - 2'd2;
    data_idx    = byte_position[2:0] - 3'd7;
    weighted    = '0;
    len_clamp   = '0;
    pending_dec = (pending_count != 8'd0) ? pending_count - 8'd1 : pending_count;

    case (ucd_mode_t'(mode))
      MODE_TX_SUBMIT, MODE_TX_FAILED: begin
        next_sequence_next = next_sequence + 16'd1;
        if (ucd_mode_t'(mode) == MODE_TX_SUBMIT) begin
          if (pending_count != 8'hFF) begin
            pending_count_next = pending_count + 8'd1;
          end
          if (pending_count_next >= max_outstanding) begin
            held_next = 1'b1;
          end
        end
        result.kind        = KIND_TX_COUNTED;
        result.tx_sequence = next_sequence_next;
      end
      MODE_RX_BYTE: begin
        if (skipping) begin
          // Drop bytes until the transfer with the bad length ends.
          if (transfer_end) begin
            skipping_next = 1'b0;
          end
        end else if (byte_position == 8'd0) begin
          // Command byte opens a new message.
          message_command_next = rx_byte;
          message_length_next  = '0;
          stamp_capture_next   = '0;
          stamp_sum_next       = '0;
          ident_capture_next   = '0;
          code_capture_next    = '0;
          payload_capture_next = '0;
          byte_position_next   = 8'd1;
        end else if (byte_position == 8'd1) begin
          message_length_next = rx_byte;
          if (rx_byte < MIN_MSG_LEN) begin
            result.kind        = KIND_BAD_LENGTH;
            byte_position_next = 8'd0;
            skipping_next      = !transfer_end;
          end else begin
            byte_position_next = 8'd2;
          end
        end else begin
          // Body capture. The stamp also feeds a running sum that is congruent
          // to it modulo 1000 and stays small.
          case (byte_position) inside
            [POS_STAMP_LO:POS_STAMP_HI]: begin
              stamp_capture_next[8*stamp_idx +: 8] = rx_byte;
              case (stamp_idx)
                2'd0:    weighted = {10'd0, rx_byte};
                2'd1:    weighted = {2'd0, rx_byte, 8'd0};
                2'd2:    weighted = STAMP_SUM_W'(rx_byte) * STAMP_SUM_W'(STAMP_WEIGHT_2);
                default: weighted = STAMP_SUM_W'(rx_byte) * STAMP_SUM_W'(STAMP_WEIGHT_3);
              endcase
              stamp_sum_next = stamp_sum + weighted;
            end
            [POS_IDENT_LO:POS_IDENT_HI]: begin
              ident_capture_next[8*ident_idx +: 8] = rx_byte;
            end
            POS_CODE: begin
              code_capture_next = rx_byte;
            end
            [POS_DATA_LO:POS_DATA_HI]: begin
              payload_capture_next[8*data_idx +: 8] = rx_byte;
            end
            default: begin
            end
          endcase

          if (({1'b0, byte_position} + 9'd1) >= {1'b0, message_length}) begin
            byte_position_next = 8'd0;
            if (message_command == CMD_TS_RECEIVE) begin
              len_clamp = (code_capture_next > 8'(MAX_FRAME_LEN)) ? MAX_FRAME_LEN
                                                                  : code_capture_next[3:0];
              result.kind      = KIND_FRAME;
              result.frame_id  = ident_capture_next;
              result.frame_len = len_clamp;
              for (int i = 0; i < 8; i++) begin
                if (4'(i) < len_clamp) begin
                  result.frame_data[8*i +: 8] = payload_capture_next[8*i +: 8];
                end
              end
              result.stamp     = stamp_capture_next;
              result.stamp_sum = stamp_sum_next;
            end else if (message_command == CMD_WRITE_ACK) begin
              pending_count_next = pending_dec;
              if (held && (pending_dec < max_outstanding)) begin
                held_next = 1'b0;
              end
              result.kind = KIND_WRITE_ACK;
            end else begin
              result.kind = KIND_OTHER;
            end
          end else begin
            byte_position_next = byte_position + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase

    result.outstanding   = pending_count_next;
    result.queue_stopped = held_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_outstanding <= MAX_OUTSTANDING_RESET;
    end else if (cfg_write) begin
      max_outstanding <= cfg_data;
    end
  end

  // Reassembly and transmit bookkeeping state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      message_command <= '0;
      message_length  <= '0;
      stamp_capture   <= '0;
      stamp_sum       <= '0;
      ident_capture   <= '0;
      code_capture    <= '0;
      payload_capture <= '0;
      skipping        <= 1'b0;
      pending_count   <= '0;
      held            <= 1'b0;
      next_sequence   <= '0;
    end else if (fire) begin
      byte_position   <= byte_position_next;
      message_command <= message_command_next;
      message_length  <= message_length_next;
      stamp_capture   <= stamp_capture_next;
      stamp_sum       <= stamp_sum_next;
      ident_capture   <= ident_capture_next;
      code_capture    <= code_capture_next;
      payload_capture <= payload_capture_next;
      skipping        <= skipping_next;
      pending_count   <= pending_count_next;
      held            <= held_next;
      next_sequence   <= next_sequence_next;
    end
  end

`ifndef SYNTH
  // A bad length never starts a body capture.
  assert property (@(posedge clk) disable iff (rst)
    fire && (result.kind == KIND_BAD_LENGTH) |=> (byte_position == 8'd0))
    else $error("bad length left the parser inside a message");

  // Every transmit item consumes exactly one sequence number.
  assert property (@(posedge clk) disable iff (rst)
    fire && (result.kind == KIND_TX_COUNTED) |=> (next_sequence == $past(next_sequence) + 16'd1))
    else $error("sequence number did not advance on a transmit item");

  // Skipping only ever starts from a bad length byte.
  assert property (@(posedge clk) disable iff (rst)
    $rose(skipping) |-> $past(result.kind == KIND_BAD_LENGTH))
    else $error("skip started without a bad length");
`endif

endmodule

### rtl/core/ucd_stamp_split.sv
// Splits a millisecond stamp into seconds and microseconds from registered quotients.
// Uses the small sum congruent to the stamp modulo 1000; depends on ucd_pkg.
module ucd_stamp_split
  import ucd_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            stamp,
  input  logic [STAMP_SUM_W-1:0] stamp_sum,
  output logic [22:0]            stamp_sec,
  output logic [19:0]            stamp_usec
);

  logic [31:0]            diff;
  logic [28:0]            diff_quot;
  logic [36:0]            sum_prod;
  logic [22:0]            whole_sec;
  logic [8:0]             sum_sec;
  logic [STAMP_SUM_W-1:0] sum_hold;
  logic [27:0]            sum_ms;
  logic [27:0]            sec_ms;

  // Stamp minus the sum is an exact multiple of 1000: divide it by 8 and
  // multiply by the inverse of 125. The sum itself is divided by reciprocal.
  assign diff      = stamp - {{(32-STAMP_SUM_W){1'b0}}, stamp_sum};
  assign diff_quot = 29'(diff[31:3] * INV_125);
  assign sum_prod  = 37'(stamp_sum) * 37'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (en) begin
      whole_sec <= diff_quot[22:0];
      sum_sec   <= sum_prod[RECIP_SHIFT +: 9];
      sum_hold  <= stamp_sum;
    end
  end

  // Microseconds are the sum's remainder times 1000.
  assign sum_ms     = 28'(sum_hold) * 28'(MS_PER_SEC);
  assign sec_ms     = 28'(sum_sec) * 28'(USEC_PER_SEC);
  assign stamp_sec  = whole_sec + {14'd0, sum_sec};
  assign stamp_usec = 20'(sum_ms - sec_ms);

endmodule
